@@ src/htc_pkg.sv @@
// Shared types and constants for the HTML comment tokenizer.
`default_nettype none

package htc_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int OUT_LEN_W       = 16;
  localparam int ERR_W           = 3;

  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_NUL  = 8'h00;

  localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_ABRUPT_EMPTY = 3'd1;
  localparam logic [ERR_W-1:0] ERR_EOF         = 3'd2;
  localparam logic [ERR_W-1:0] ERR_NUL         = 3'd3;
  localparam logic [ERR_W-1:0] ERR_NESTED      = 3'd4;
  localparam logic [ERR_W-1:0] ERR_BAD_CLOSE   = 3'd5;

  typedef enum logic [10:0] {
    M_IDLE  = 11'b000_0000_0001,
    M_START = 11'b000_0000_0010,
    M_SDASH = 11'b000_0000_0100,
    M_TEXT  = 11'b000_0000_1000,
    M_LT    = 11'b000_0001_0000,
    M_LB    = 11'b000_0010_0000,
    M_LBD   = 11'b000_0100_0000,
    M_LBDD  = 11'b000_1000_0000,
    M_EDASH = 11'b001_0000_0000,
    M_END   = 11'b010_0000_0000,
    M_EBANG = 11'b100_0000_0000
  } htc_mode_t;

  typedef struct packed {
    logic                 done;
    logic [ERR_W-1:0]     err;
    logic [OUT_LEN_W-1:0] len;
    logic                 had_null;
  } htc_result_t;

endpackage : htc_pkg

`default_nettype wire

@@ src/htc_step.sv @@
// Per-byte state transition and result logic, reconsume chain resolved combinationally in up to three passes.
`default_nettype none

module htc_step #(
  parameter int LENGTH_BITS = htc_pkg::LENGTH_BITS_DEF
) (
  input  htc_pkg::htc_mode_t    mode_i,
  input  logic [LENGTH_BITS-1:0] count_i,
  input  logic                  null_i,
  input  logic                  cmd_i,
  input  logic [7:0]            char_i,
  input  logic                  eof_i,
  output htc_pkg::htc_mode_t    mode_o,
  output logic [LENGTH_BITS-1:0] count_o,
  output logic                  null_o,
  output htc_pkg::htc_result_t  res_o
);
  import htc_pkg::*;

  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS+OUT_LEN_W-1:0] OUT_MAX_W =
    {{LENGTH_BITS{1'b0}}, {OUT_LEN_W{1'b1}}};

  typedef struct packed {
    htc_mode_t        nm;
    logic             more;
    logic             bump;
    logic [ERR_W-1:0] err;
    logic             emit;
    logic             empty;
    logic [1:0]       trim;
    logic             nul;
  } htc_pass_t;

  function automatic htc_pass_t pass(input htc_mode_t m, input logic [7:0] c,
                                     input logic eof);
    htc_pass_t p;
    p = '{nm: m, more: 1'b0, bump: 1'b0, err: ERR_NONE, emit: 1'b0,
          empty: 1'b0, trim: 2'd0, nul: 1'b0};
    case (m)
      M_START: begin
        if (eof) begin p.nm = M_TEXT; p.more = 1'b1; end
        else if (c == CH_DASH) begin p.nm = M_SDASH; p.bump = 1'b1; end
        else if (c == CH_GT) begin
          p.err = ERR_ABRUPT_EMPTY; p.emit = 1'b1; p.empty = 1'b1;
        end else begin p.nm = M_TEXT; p.more = 1'b1; end
      end
      M_SDASH: begin
        if (eof) begin p.err = ERR_EOF; p.emit = 1'b1; p.empty = 1'b1; end
        else if (c == CH_DASH) begin p.nm = M_END; p.bump = 1'b1; end
        else if (c == CH_GT) begin
          p.err = ERR_ABRUPT_EMPTY; p.emit = 1'b1; p.empty = 1'b1;
        end else begin p.nm = M_TEXT; p.more = 1'b1; end
      end
      M_TEXT: begin
        if (eof) begin p.err = ERR_EOF; p.emit = 1'b1; end
        else if (c == CH_LT) begin p.nm = M_LT; p.bump = 1'b1; end
        else if (c == CH_DASH) begin p.nm = M_EDASH; p.bump = 1'b1; end
        else if (c == CH_NUL) begin
          p.nul = 1'b1; p.err = ERR_NUL; p.bump = 1'b1;
        end else p.bump = 1'b1;
      end
      M_LT: begin
        if (eof) begin p.nm = M_TEXT; p.more = 1'b1; end
        else if (c == CH_BANG) begin p.nm = M_LB; p.bump = 1'b1; end
        else if (c == CH_LT) p.bump = 1'b1;
        else begin p.nm = M_TEXT; p.more = 1'b1; end
      end
      M_LB: begin
        if (!eof && c == CH_DASH) begin p.nm = M_LBD; p.bump = 1'b1; end
        else begin p.nm = M_TEXT; p.more = 1'b1; end
      end
      M_LBD: begin
        if (!eof && c == CH_DASH) begin p.nm = M_LBDD; p.bump = 1'b1; end
        else begin p.nm = M_EDASH; p.more = 1'b1; end
      end
      M_LBDD: begin
        if (!eof && c != CH_GT) p.err = ERR_NESTED;
        p.nm = M_END;
        p.more = 1'b1;
      end
      M_EDASH: begin
        if (eof) begin p.err = ERR_EOF; p.emit = 1'b1; p.trim = 2'd1; end
        else if (c == CH_DASH) begin p.nm = M_END; p.bump = 1'b1; end
        else begin p.nm = M_TEXT; p.more = 1'b1; end
      end
      M_END: begin
        if (eof) begin p.err = ERR_EOF; p.emit = 1'b1; p.trim = 2'd2; end
        else if (c == CH_GT) begin p.emit = 1'b1; p.trim = 2'd2; end
        else if (c == CH_BANG) begin p.nm = M_EBANG; p.bump = 1'b1; end
        else if (c == CH_DASH) p.bump = 1'b1;
        else begin p.nm = M_TEXT; p.more = 1'b1; end
      end
      M_EBANG: begin
        if (eof) begin p.err = ERR_EOF; p.emit = 1'b1; p.trim = 2'd3; end
        else if (c == CH_DASH) begin p.nm = M_EDASH; p.bump = 1'b1; end
        else if (c == CH_GT) begin
          p.err = ERR_BAD_CLOSE; p.emit = 1'b1; p.trim = 2'd3;
        end else begin p.nm = M_TEXT; p.more = 1'b1; end
      end
      default: p.nm = M_IDLE;
    endcase
    return p;
  endfunction

  htc_pass_t p1, p2, p3, fin;
  logic [ERR_W-1:0] err;
  logic [LENGTH_BITS-1:0] cnt_inc;
  logic [LENGTH_BITS-1:0] trim_w;
  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS+OUT_LEN_W-1:0] len_w;
  logic nul_upd;

  // chains are at most three passes deep (e.g. bang-dash-dash -> end -> text)
  always_comb begin
    p1 = pass(mode_i, char_i, eof_i);
    p2 = pass(p1.nm, char_i, eof_i);
    p3 = pass(p2.nm, char_i, eof_i);
    fin = !p1.more ? p1 : (!p2.more ? p2 : p3);

    if (p1.err != ERR_NONE) err = p1.err;
    else if (p1.more && p2.err != ERR_NONE) err = p2.err;
    else if (p1.more && p2.more) err = p3.err;
    else err = ERR_NONE;

    cnt_inc = (fin.bump && count_i != COUNT_MAX) ? count_i + 1'b1 : count_i;
    nul_upd = null_i | fin.nul;

    trim_w = LENGTH_BITS'(fin.trim);
    if (fin.empty || count_i < trim_w) len = '0;
    else len = count_i - trim_w;
    len_w = {{OUT_LEN_W{1'b0}}, len};

    mode_o  = fin.nm;
    count_o = cnt_inc;
    null_o  = nul_upd;
    res_o   = '0;

    if (cmd_i) begin
      mode_o  = M_START;
      count_o = '0;
      null_o  = 1'b0;
    end else begin
      res_o.err = err;
      if (fin.emit) begin
        mode_o         = M_IDLE;
        res_o.done     = 1'b1;
        res_o.had_null = nul_upd;
        res_o.len      = (len_w > OUT_MAX_W) ? {OUT_LEN_W{1'b1}} : len_w[OUT_LEN_W-1:0];
      end
    end
  end

endmodule : htc_step

`default_nettype wire

@@ src/html_comment_tokenizer.sv @@
// Top level of the HTML comment tokenizer: input register, step logic, result register.
`default_nettype none

// Takes one byte (or a begin/end-of-input beat) per cycle and returns exactly one result
// beat per input beat. Each accepted input beat is held in the input register, then its
// result is loaded into the result register, which drives out_tvalid until it is taken.
// Throughput is one beat per cycle unless the output stalls; the htc_step state update is
// combinational and resolves reconsume chains of up to three passes within the cycle.
// Result beats carry error codes for every input; the length and NUL flag are only
// meaningful on beats with out_tlast (comment completed). The byte counter is
// LENGTH_BITS wide and saturates; the reported length saturates at 65535.

module html_comment_tokenizer #(
  parameter int LENGTH_BITS = htc_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic [1:0]  in_tuser,   // [0] cmd, [1] at_eof
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tlast,  // done_res
  output logic [23:0] out_tdata   // [2:0] error_code, [18:3] text_length, [19] had_null
);
  import htc_pkg::*;

  logic                   in_valid_r;
  logic                   in_cmd_r;
  logic [7:0]             in_char_r;
  logic                   in_eof_r;
  htc_mode_t              mode_r, mode_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  logic                   null_r, null_nxt;
  logic                   out_valid_r;
  htc_result_t            res_r, res_nxt;
  logic                   advance;
  logic                   in_fire;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  htc_step #(.LENGTH_BITS(LENGTH_BITS)) u_step (
    .mode_i  (mode_r),
    .count_i (count_r),
    .null_i  (null_r),
    .cmd_i   (in_cmd_r),
    .char_i  (in_char_r),
    .eof_i   (in_eof_r),
    .mode_o  (mode_nxt),
    .count_o (count_nxt),
    .null_o  (null_nxt),
    .res_o   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= M_IDLE;
      count_r     <= '0;
      null_r      <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) begin
        out_valid_r <= 1'b1;
        mode_r      <= mode_nxt;
        count_r     <= count_nxt;
        null_r      <= null_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_cmd_r  <= in_tuser[0];
      in_eof_r  <= in_tuser[1];
      in_char_r <= in_tdata;
    end
    if (advance) res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = res_r.done;
  assign out_tdata  = {4'b0, res_r.had_null, res_r.len, res_r.err};

endmodule : html_comment_tokenizer

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking stream testbench for the HTML comment tokenizer.
`timescale 1ns / 1ps

module tb_top;
  import htc_pkg::*;

  localparam int CNT_W      = LENGTH_BITS_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL       = 20;
  localparam int RAND_ITEMS = 380;
  localparam int LONG_BYTES = 40;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
    logic       eof;
    logic       drain;   // hold this beat back until every result is in
    logic       steady;  // no driver gap after this beat; receiver ready unless a hold is pending
  } tok_beat_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [1:0]  in_tuser = 2'b00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        out_tlast;
  logic [23:0] out_tdata;

  html_comment_tokenizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tlast (out_tlast),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  tok_beat_t   beat_q[$];
  htc_result_t token_q[$];

  // tokenizer state as predicted
  htc_mode_t        tok_mode  = M_IDLE;
  logic [CNT_W-1:0] tok_count = '0;
  logic             tok_nul   = 1'b0;

  int  in_cnt = 0, res_cnt = 0, done_cnt = 0, mismatch_cnt = 0, max_len = 0;
  int  err_seen[6];
  bit  gen_steady = 0;
  bit  in_steady = 0;
  logic in_taken = 1'b0;
  int  tx_gap = 0, sent_cnt = 0;
  int  rx_gap = 0;
  bit  hold1_done = 0, hold2_done = 0;
  int  idle_cycles = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ERR_W-1:0] first_err(logic [ERR_W-1:0] cur,
                                                 logic [ERR_W-1:0] code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic htc_result_t tok_predict(logic cmd, logic [7:0] c, logic eof);
    htc_result_t      r;
    logic [ERR_W-1:0] err;
    int               trim;
    bit               emit, empty, more;
    longint unsigned  len;
    r = '0;
    err = ERR_NONE;
    trim = 0;
    emit = 0;
    empty = 0;
    more = 1;
    if (cmd) begin
      tok_mode  = M_START;
      tok_count = '0;
      tok_nul   = 1'b0;
      more      = 0;
    end
    while (more) begin
      more = 0;
      case (tok_mode)
        M_START: begin
          if (eof) begin tok_mode = M_TEXT; more = 1; end
          else if (c == CH_DASH) begin tok_mode = M_SDASH; tok_count = sat_inc(tok_count); end
          else if (c == CH_GT) begin
            err = first_err(err, ERR_ABRUPT_EMPTY); emit = 1; empty = 1;
          end else begin tok_mode = M_TEXT; more = 1; end
        end
        M_SDASH: begin
          if (eof) begin err = first_err(err, ERR_EOF); emit = 1; empty = 1; end
          else if (c == CH_DASH) begin tok_mode = M_END; tok_count = sat_inc(tok_count); end
          else if (c == CH_GT) begin
            err = first_err(err, ERR_ABRUPT_EMPTY); emit = 1; empty = 1;
          end else begin tok_mode = M_TEXT; more = 1; end
        end
        M_TEXT: begin
          if (eof) begin err = first_err(err, ERR_EOF); emit = 1; trim = 0; end
          else if (c == CH_LT) begin tok_mode = M_LT; tok_count = sat_inc(tok_count); end
          else if (c == CH_DASH) begin tok_mode = M_EDASH; tok_count = sat_inc(tok_count); end
          else if (c == CH_NUL) begin
            tok_nul = 1'b1; err = first_err(err, ERR_NUL); tok_count = sat_inc(tok_count);
          end else tok_count = sat_inc(tok_count);
        end
        M_LT: begin
          if (eof) begin tok_mode = M_TEXT; more = 1; end
          else if (c == CH_BANG) begin tok_mode = M_LB; tok_count = sat_inc(tok_count); end
          else if (c == CH_LT) tok_count = sat_inc(tok_count);
          else begin tok_mode = M_TEXT; more = 1; end
        end
        M_LB: begin
          if (!eof && c == CH_DASH) begin tok_mode = M_LBD; tok_count = sat_inc(tok_count); end
          else begin tok_mode = M_TEXT; more = 1; end
        end
        M_LBD: begin
          if (!eof && c == CH_DASH) begin tok_mode = M_LBDD; tok_count = sat_inc(tok_count); end
          else begin tok_mode = M_EDASH; more = 1; end
        end
        M_LBDD: begin
          if (!eof && c != CH_GT) err = first_err(err, ERR_NESTED);
          tok_mode = M_END;
          more = 1;
        end
        M_EDASH: begin
          if (eof) begin err = first_err(err, ERR_EOF); emit = 1; trim = 1; end
          else if (c == CH_DASH) begin tok_mode = M_END; tok_count = sat_inc(tok_count); end
          else begin tok_mode = M_TEXT; more = 1; end
        end
        M_END: begin
          if (eof) begin err = first_err(err, ERR_EOF); emit = 1; trim = 2; end
          else if (c == CH_GT) begin emit = 1; trim = 2; end
          else if (c == CH_BANG) begin tok_mode = M_EBANG; tok_count = sat_inc(tok_count); end
          else if (c == CH_DASH) tok_count = sat_inc(tok_count);
          else begin tok_mode = M_TEXT; more = 1; end
        end
        M_EBANG: begin
          if (eof) begin err = first_err(err, ERR_EOF); emit = 1; trim = 3; end
          else if (c == CH_DASH) begin tok_mode = M_EDASH; tok_count = sat_inc(tok_count); end
          else if (c == CH_GT) begin err = first_err(err, ERR_BAD_CLOSE); emit = 1; trim = 3; end
          else begin tok_mode = M_TEXT; more = 1; end
        end
        default: tok_mode = M_IDLE;
      endcase
    end
    if (emit) begin
      if (empty) len = 0;
      else len = (longint'(tok_count) >= trim) ? longint'(tok_count) - trim : 0;
      if (len > 64'hFFFF) len = 64'hFFFF;
      r.done     = 1'b1;
      r.len      = len[OUT_LEN_W-1:0];
      r.had_null = tok_nul;
      tok_mode   = M_IDLE;
    end
    r.err = err;
    return r;
  endfunction

  task automatic add_beat(logic cmd, logic [7:0] ch, logic eof, logic drain);
    tok_beat_t b;
    b.cmd = cmd;
    b.ch = ch;
    b.eof = eof;
    b.drain = drain;
    b.steady = gen_steady;
    beat_q.push_back(b);
  endtask

  task automatic put_begin(logic drain);
    add_beat(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), drain);
  endtask

  task automatic put_byte(logic [7:0] ch);
    add_beat(1'b0, ch, 1'b0, 1'b0);
  endtask

  task automatic put_eof();
    add_beat(1'b0, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // driver
  always @(negedge clk) begin : tx_drive
    tok_beat_t b;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        in_tvalid <= 1'b0;
      end else if (beat_q.size() == 0 || (beat_q[0].drain && token_q.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else begin
        b = beat_q.pop_front();
        in_tdata  <= b.ch;
        in_tuser  <= {b.eof, b.cmd};
        in_tvalid <= 1'b1;
        in_steady <= b.steady;
        sent_cnt  <= sent_cnt + 1;
        tx_gap    <= (b.steady || (sent_cnt / 50) % 4 == 2) ? 0 : pick_gap();
      end
    end
  end

  // receiver
  always @(negedge clk) begin : rx_drive
    int g;
    if (!hold1_done && res_cnt >= 120) begin
      hold1_done <= 1;
      rx_gap <= 300;
      out_tready <= 1'b0;
    end else if (!hold2_done && res_cnt >= 400) begin
      hold2_done <= 1;
      rx_gap <= 250;
      out_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1;
      out_tready <= 1'b0;
    end else if (in_steady || (res_cnt / 60) % 4 == 3) begin
      out_tready <= 1'b1;
    end else begin
      g = pick_gap();
      if (g == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        rx_gap <= g - 1;
      end
    end
  end

  // prediction and checking
  always @(posedge clk) begin : score
    htc_result_t want;
    logic [2:0]  got_err;
    logic [15:0] got_len;
    logic        got_nul;
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_err = out_tdata[2:0];
        got_len = out_tdata[18:3];
        got_nul = out_tdata[19];
        res_cnt++;
        if (token_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: result beat with nothing expected: %s",
                     $sformatf("last=%0b err=%0d len=%0d nul=%0b",
                               out_tlast, got_err, got_len, got_nul));
        end else begin
          want = token_q.pop_front();
          if (out_tlast !== want.done || got_err !== want.err ||
              got_len !== want.len || got_nul !== want.had_null) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("ERROR: result %0d: exp %s, got %s", res_cnt,
                       $sformatf("done=%0b err=%0d len=%0d nul=%0b",
                                 want.done, want.err, want.len, want.had_null),
                       $sformatf("done=%0b err=%0d len=%0d nul=%0b",
                                 out_tlast, got_err, got_len, got_nul));
          end
          if (want.done) begin
            done_cnt++;
            if (int'(want.len) > max_len) max_len = want.len;
          end
          if (want.err <= ERR_BAD_CLOSE) err_seen[want.err]++;
        end
      end
      if (in_tvalid && in_tready) begin
        in_cnt++;
        token_q.push_back(tok_predict(in_tuser[0], in_tdata, in_tuser[1]));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no beat moved for %0d cycles, %0d results outstanding",
               idle_cycles, token_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stim
    int n_dir, n_body, r, n_comment;
    // directed
    put_byte("A");
    put_eof();
    put_begin(1'b0); put_byte(CH_GT);
    put_begin(1'b0); put_byte(CH_DASH); put_byte(CH_GT);
    put_begin(1'b0); put_byte(CH_DASH); put_eof();
    put_begin(1'b0); put_eof();
    put_begin(1'b0); put_byte("q");
    put_begin(1'b0);
    put_byte(8'hFF); put_byte(CH_NUL); put_text("<!--x--!>");
    put_begin(1'b0); put_text("<!--->");
    n_dir = beat_q.size();

    // random: mostly well-formed comments, some noise
    n_comment = 0;
    while (beat_q.size() < n_dir + RAND_ITEMS) begin
      if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 4))
          add_beat(1'($urandom_range(0, 99) < 20), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 99) < 20), 1'b0);
      end else begin
        put_begin(n_comment == 15 || n_comment == 45);
        n_comment++;
        n_body = $urandom_range(0, 10);
        repeat (n_body) begin
          r = $urandom_range(0, 14);
          case (r)
            0: put_byte(CH_DASH);
            1: put_text("--");
            2: put_text("--!");
            3: put_text("<!--");
            4: put_text("<!-");
            5: put_byte(CH_LT);
            6: put_byte(CH_BANG);
            7: put_byte(CH_NUL);
            8: put_byte(CH_GT);
            9: put_text("<<!");
            default: put_byte(8'($urandom_range(0, 255)));
          endcase
        end
        r = $urandom_range(0, 10);
        case (r)
          4: put_text("--!>");
          5: put_eof();
          6: put_text("->");
          7: put_byte(CH_GT);
          8: ;
          9: begin put_text("--!"); put_eof(); end
          10: begin put_byte(CH_DASH); put_eof(); end
          default: put_text("-->");
        endcase
      end
    end

    // long comments, run back to back
    gen_steady = 1;
    put_begin(1'b1);
    repeat (LONG_BYTES) put_byte(8'($urandom_range("a", "z")));
    put_eof();
    put_begin(1'b0);
    repeat (LONG_BYTES) put_byte(8'($urandom_range("a", "z")));
    put_text("--!>");

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (beat_q.size() != 0 || in_tvalid) @(posedge clk);
    while (token_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("Covered %0d input beats, %0d result beats, %0d comments completed, longest %0d",
             in_cnt, res_cnt, done_cnt, max_len);
    $display("Error codes: none %0d, empty close %0d, eof %0d, nul %0d, %s",
             err_seen[0], err_seen[1], err_seen[2], err_seen[3],
             $sformatf("nested %0d, bad close %0d", err_seen[4], err_seen[5]));
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
